>>> hw/rtl/rpcf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpcf_pkg
// Shared types, widths and coefficient tables of the rgb pixel colour filter.
// ---------------------------------------------------------------------------
package rpcf_pkg;

   localparam int COLOR_W    = 8;
   localparam int COEF_W     = 16;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = COLOR_W + COEF_W;
   // three products of at most 255 * 50397 each stay below 2^26
   localparam int SUM_W      = PROD_W + 2;
   localparam int LEVEL_W    = SUM_W - FRAC_W;
   localparam int CHANNELS   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [COLOR_W-1:0] MAX_COLOR_RESET = 8'd255;

   typedef enum logic [1:0] {
      MODE_GRAY     = 2'd0,
      MODE_SEPIA    = 2'd1,
      MODE_NEGATIVE = 2'd2,
      MODE_PASS     = 2'd3
   } filter_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_MODE = 2'd0,
      CSR_MAX_COLOR   = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red_in;
      logic [COLOR_W-1:0] green_in;
      logic [COLOR_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red_out;
      logic [COLOR_W-1:0] green_out;
      logic [COLOR_W-1:0] blue_out;
   } rsp_type;

   typedef logic [CHANNELS-1:0][COLOR_W-1:0] chan_type;

   typedef struct packed {
      logic [CHANNELS-1:0][CHANNELS-1:0][PROD_W-1:0] prod;
      req_type                                       px;
   } prod_stage_type;

   typedef struct packed {
      logic [CHANNELS-1:0][LEVEL_W-1:0] level;
      req_type                          px;
   } sum_stage_type;

   // channel 0 red, 1 green, 2 blue
   function automatic chan_type split_pixel(input req_type px);
      chan_type c;
      c[0] = px.red_in;
      c[1] = px.green_in;
      c[2] = px.blue_in;
      return c;
   endfunction

   // q0.16 weight of input channel col for output channel row
   function automatic logic [COEF_W-1:0] coef_lookup(input filter_mode_type mode,
                                                     input logic [1:0] row,
                                                     input logic [1:0] col);
      logic [COEF_W-1:0] c;
      c = '0;
      if (mode == MODE_GRAY) begin
         case (col)
            2'd0:    c = 16'd19595;
            2'd1:    c = 16'd38470;
            2'd2:    c = 16'd7471;
            default: c = '0;
         endcase
      end else begin
         case ({row, col})
            4'b00_00: c = 16'd25756;
            4'b00_01: c = 16'd50397;
            4'b00_10: c = 16'd12386;
            4'b01_00: c = 16'd22872;
            4'b01_01: c = 16'd44958;
            4'b01_10: c = 16'd11010;
            4'b10_00: c = 16'd17826;
            4'b10_01: c = 16'd34996;
            4'b10_10: c = 16'd8585;
            default:  c = '0;
         endcase
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/rpcf_mult_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpcf_mult_stage
// First pipeline stage: nine channel by weight products, registered.
// ---------------------------------------------------------------------------
module rpcf_mult_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  rpcf_pkg::filter_mode_type filter_mode,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rpcf_pkg::req_type        in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rpcf_pkg::prod_stage_type out_data
);

   logic                     valid_ff;
   logic                     valid_in;
   rpcf_pkg::prod_stage_type data_ff;
   rpcf_pkg::prod_stage_type data_in;

   always_comb begin
      rpcf_pkg::chan_type c;
      c = rpcf_pkg::split_pixel(in_data);
      data_in.px = in_data;
      for (int r = 0; r < rpcf_pkg::CHANNELS; r++) begin
         for (int k = 0; k < rpcf_pkg::CHANNELS; k++) begin
            data_in.prod[r][k] = rpcf_pkg::PROD_W'(c[k]) *
               rpcf_pkg::PROD_W'(rpcf_pkg::coef_lookup(filter_mode, 2'(r), 2'(k)));
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/rpcf_sum_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpcf_sum_stage
// Second pipeline stage: per channel sum of products, truncated to integer.
// ---------------------------------------------------------------------------
module rpcf_sum_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rpcf_pkg::prod_stage_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rpcf_pkg::sum_stage_type  out_data
);

   logic                    valid_ff;
   logic                    valid_in;
   rpcf_pkg::sum_stage_type data_ff;
   rpcf_pkg::sum_stage_type data_in;

   always_comb begin
      logic [rpcf_pkg::SUM_W-1:0] sum;
      data_in.px = in_data.px;
      for (int r = 0; r < rpcf_pkg::CHANNELS; r++) begin
         sum = rpcf_pkg::SUM_W'(in_data.prod[r][0]) + rpcf_pkg::SUM_W'(in_data.prod[r][1]) +
               rpcf_pkg::SUM_W'(in_data.prod[r][2]);
         // drop the fraction bits
         data_in.level[r] = sum[rpcf_pkg::SUM_W-1:rpcf_pkg::FRAC_W];
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/rpcf_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpcf_out_stage
// Last pipeline stage: clamp, mode select and low bit copy into the result.
// ---------------------------------------------------------------------------
module rpcf_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  rpcf_pkg::filter_mode_type filter_mode,
   input  logic [rpcf_pkg::COLOR_W-1:0] max_color,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rpcf_pkg::sum_stage_type   in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rpcf_pkg::rsp_type         out_data
);

   logic              valid_ff;
   logic              valid_in;
   rpcf_pkg::rsp_type data_ff;
   rpcf_pkg::rsp_type data_in;

   always_comb begin
      rpcf_pkg::chan_type          c;
      rpcf_pkg::chan_type          res;
      logic [rpcf_pkg::COLOR_W-1:0] clamped;
      c   = rpcf_pkg::split_pixel(in_data.px);
      res = '0;
      for (int k = 0; k < rpcf_pkg::CHANNELS; k++) begin
         if (in_data.level[k] > rpcf_pkg::LEVEL_W'(max_color)) begin
            clamped = max_color;
         end else begin
            clamped = in_data.level[k][rpcf_pkg::COLOR_W-1:0];
         end
         case (filter_mode)
            rpcf_pkg::MODE_GRAY,
            rpcf_pkg::MODE_SEPIA:    res[k] = clamped;
            rpcf_pkg::MODE_NEGATIVE: res[k] = ~c[k];
            default:                 res[k] = c[k];
         endcase
         // keep the hidden low bit of the source channel
         res[k][0] = c[k][0];
      end
      data_in.red_out   = res[0];
      data_in.green_out = res[1];
      data_in.blue_out  = res[2];
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/rgb_pixel_color_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_pixel_color_filter
// Grayscale, sepia or negative filter on a stream of 8-bit rgb pixels.
// ---------------------------------------------------------------------------
// Takes one pixel beat per clock and returns one filtered pixel beat per
// clock while rsp_ready stays high (multiply, sum, clamp/select stages,
// each with its own valid bit so a stalled result holds the pipe without
// losing or repeating a beat). Register 0 selects the filter (0 grayscale,
// 1 sepia, 2 negative, 3 pass-through), register 1 is the clamp for
// grayscale and sepia. Bit 0 of each output channel is copied from its input
// channel. Registers are to be written only while no pixel is in flight.
module rgb_pixel_color_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rpcf_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rpcf_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rpcf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpcf_pkg::CSR_DATA_W-1:0]   csr_data
);

   rpcf_pkg::filter_mode_type    filter_mode_ff;
   logic [rpcf_pkg::COLOR_W-1:0] max_color_ff;

   logic                     s1_valid;
   logic                     s1_ready;
   rpcf_pkg::prod_stage_type s1_data;
   logic                     s2_valid;
   logic                     s2_ready;
   rpcf_pkg::sum_stage_type  s2_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff <= rpcf_pkg::MODE_GRAY;
         max_color_ff   <= rpcf_pkg::MAX_COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rpcf_pkg::CSR_FILTER_MODE: filter_mode_ff <= rpcf_pkg::filter_mode_type'(csr_data[1:0]);
            rpcf_pkg::CSR_MAX_COLOR:   max_color_ff   <= csr_data[rpcf_pkg::COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   rpcf_mult_stage u_mult (
      .clock       (clock),
      .reset       (reset),
      .filter_mode (filter_mode_ff),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_data     (req_data),
      .out_valid   (s1_valid),
      .out_ready   (s1_ready),
      .out_data    (s1_data)
   );

   rpcf_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   rpcf_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .filter_mode (filter_mode_ff),
      .max_color   (max_color_ff),
      .in_valid    (s2_valid),
      .in_ready    (s2_ready),
      .in_data     (s2_data),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_data    (rsp_data)
   );

endmodule

>>> tb/sv/rgb_pixel_color_filter_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_pixel_color_filter_test
// Self-checking bench for the rgb pixel colour filter.
// ---------------------------------------------------------------------------
// A short table of directed pixels runs first across every filter mode, the
// clamp extremes and the masked register writes, followed by random phases,
// each with its own register setting. Every returned pixel is checked field
// by field against a local model or a table value, with random sender bursts,
// receiver stalls and two long receiver hold-offs that back up the pipe.
module rgb_pixel_color_filter_test;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASES        = 10;
   localparam int PHASE_PIXELS  = 45;
   localparam int ROWS          = 20;

   // the two register indexes that no register answers to
   localparam logic [rpcf_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [rpcf_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   // q0.16 weights
   localparam int unsigned GRAY_R  = 19595;
   localparam int unsigned GRAY_G  = 38470;
   localparam int unsigned GRAY_B  = 7471;
   localparam int unsigned SEP_RR  = 25756;
   localparam int unsigned SEP_RG  = 50397;
   localparam int unsigned SEP_RB  = 12386;
   localparam int unsigned SEP_GR  = 22872;
   localparam int unsigned SEP_GG  = 44958;
   localparam int unsigned SEP_GB  = 11010;
   localparam int unsigned SEP_BR  = 17826;
   localparam int unsigned SEP_BG  = 34996;
   localparam int unsigned SEP_BB  = 8585;

   typedef struct packed {
      logic [7:0]        mode_data;
      logic [7:0]        max_data;
      rpcf_pkg::req_type px;
      logic              typed;
      rpcf_pkg::rsp_type want;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   rpcf_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_ready;
   rpcf_pkg::rsp_type               rsp_data;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [rpcf_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rpcf_pkg::CSR_DATA_W-1:0] csr_data;

   logic                            typed_flag;
   rpcf_pkg::rsp_type               typed_value;
   logic                            hold_off_go = 1'b0;

   rpcf_pkg::filter_mode_type       mode_shadow;
   logic [7:0]                      max_color_shadow;
   rpcf_pkg::rsp_type               pending_pixels[$];
   int                              fault_count = 0;
   int                              quiet_cycles = 0;
   stim_row_type                    stim_table [ROWS];

   rgb_pixel_color_filter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [7:0] weigh_channels(input int unsigned ka, kb, kc,
                                                 input logic [7:0] a, b, c,
                                                 input logic [7:0] ceiling);
      int unsigned total;
      total = (ka * a + kb * b + kc * c) >> 16;
      if (total < ceiling) begin
         return total[7:0];
      end
      return ceiling;
   endfunction

   function automatic rpcf_pkg::rsp_type filter_pixel(input rpcf_pkg::req_type px,
                                                      input rpcf_pkg::filter_mode_type mode,
                                                      input logic [7:0] ceiling);
      logic [7:0]        lvl_r;
      logic [7:0]        lvl_g;
      logic [7:0]        lvl_b;
      rpcf_pkg::rsp_type o;
      case (mode)
         rpcf_pkg::MODE_GRAY: begin
            lvl_r = weigh_channels(GRAY_R, GRAY_G, GRAY_B,
                                   px.red_in, px.green_in, px.blue_in, ceiling);
            lvl_g = lvl_r;
            lvl_b = lvl_r;
         end
         rpcf_pkg::MODE_SEPIA: begin
            lvl_r = weigh_channels(SEP_RR, SEP_RG, SEP_RB,
                                   px.red_in, px.green_in, px.blue_in, ceiling);
            lvl_g = weigh_channels(SEP_GR, SEP_GG, SEP_GB,
                                   px.red_in, px.green_in, px.blue_in, ceiling);
            lvl_b = weigh_channels(SEP_BR, SEP_BG, SEP_BB,
                                   px.red_in, px.green_in, px.blue_in, ceiling);
         end
         rpcf_pkg::MODE_NEGATIVE: begin
            lvl_r = 8'd255 - px.red_in;
            lvl_g = 8'd255 - px.green_in;
            lvl_b = 8'd255 - px.blue_in;
         end
         default: begin
            lvl_r = px.red_in;
            lvl_g = px.green_in;
            lvl_b = px.blue_in;
         end
      endcase
      // low bit of each channel carries through from the input
      o.red_out   = {lvl_r[7:1], px.red_in[0]};
      o.green_out = {lvl_g[7:1], px.green_in[0]};
      o.blue_out  = {lvl_b[7:1], px.blue_in[0]};
      return o;
   endfunction

   function automatic stim_row_type make_row(input logic [7:0] mode_data, max_data,
                                             input logic [7:0] r, g, b,
                                             input logic typed,
                                             input logic [7:0] wr, wg, wb);
      stim_row_type row;
      row.mode_data      = mode_data;
      row.max_data       = max_data;
      row.px.red_in      = r;
      row.px.green_in    = g;
      row.px.blue_in     = b;
      row.typed          = typed;
      row.want.red_out   = wr;
      row.want.green_out = wg;
      row.want.blue_out  = wb;
      return row;
   endfunction

   function automatic logic [7:0] pick_level();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd1;
         3:       return 8'd254;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic report_fault(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fault_count++;
   endtask

   // scoreboard: pop on the result beat first, then queue up the pixel beat
   always @(posedge clock) begin
      rpcf_pkg::rsp_type want;
      rpcf_pkg::rsp_type fresh;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_fault($sformatf("unexpected result %h", rsp_data));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.red_out !== want.red_out)
               report_fault($sformatf("red_out %h, expected %h",
                                      rsp_data.red_out, want.red_out));
            if (rsp_data.green_out !== want.green_out)
               report_fault($sformatf("green_out %h, expected %h",
                                      rsp_data.green_out, want.green_out));
            if (rsp_data.blue_out !== want.blue_out)
               report_fault($sformatf("blue_out %h, expected %h",
                                      rsp_data.blue_out, want.blue_out));
         end
      end
      if (!reset && req_valid && req_ready) begin
         if (typed_flag) begin
            fresh = typed_value;
         end else begin
            fresh = filter_pixel(req_data, mode_shadow, max_color_shadow);
         end
         pending_pixels = {pending_pixels, fresh};
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[rgb_pixel_color_filter] ERROR");
            $finish;
         end
      end
   end

   // receiver: random stall rate, redrawn only outside a hold, plus the long hold
   initial begin
      int hold_left;
      int stall_pct;
      int tick;
      hold_left = 0;
      stall_pct = 0;
      tick      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_off_go <= 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (tick % 32 == 0) begin
               case ($urandom_range(4))
                  0, 1:    stall_pct = 0;
                  2:       stall_pct = 25;
                  3:       stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            tick++;
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic offer_pixel(input rpcf_pkg::req_type px, input logic typed,
                              input rpcf_pkg::rsp_type want);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_data    <= px;
      typed_flag  <= typed;
      typed_value <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_cycles(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // stop offering and let every outstanding beat come back
   task automatic drain_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [rpcf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == rpcf_pkg::CSR_FILTER_MODE) begin
         mode_shadow = rpcf_pkg::filter_mode_type'(value[1:0]);
      end else if (idx == rpcf_pkg::CSR_MAX_COLOR) begin
         max_color_shadow = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0]        cur_mode_data;
      logic [7:0]        cur_max_data;
      logic [1:0]        mode_pick;
      logic [7:0]        max_pick;
      rpcf_pkg::req_type px;
      rpcf_pkg::rsp_type none;
      int                burst_left;
      int                gap;
      bit                steady;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      typed_flag       = 1'b0;
      typed_value      = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      mode_shadow      = rpcf_pkg::MODE_GRAY;
      max_color_shadow = rpcf_pkg::MAX_COLOR_RESET;
      none             = '0;

      // grayscale at reset values
      stim_table[0]  = make_row(8'h00, 8'hFF, 8'd0,   8'd0,   8'd0,   1, 8'd0, 8'd0, 8'd0);
      stim_table[1]  = make_row(8'h00, 8'hFF, 8'd255, 8'd255, 8'd255,
                                1, 8'd255, 8'd255, 8'd255);
      stim_table[2]  = make_row(8'h00, 8'hFF, 8'd255, 8'd0,   8'd0,   0, 0, 0, 0);
      stim_table[3]  = make_row(8'h00, 8'hFF, 8'd0,   8'd255, 8'd0,   0, 0, 0, 0);
      stim_table[4]  = make_row(8'h00, 8'hFF, 8'd0,   8'd0,   8'd255, 0, 0, 0, 0);
      // sepia, full range
      stim_table[5]  = make_row(8'h01, 8'hFF, 8'd255, 8'd255, 8'd255, 0, 0, 0, 0);
      stim_table[6]  = make_row(8'h01, 8'hFF, 8'd0,   8'd0,   8'd0,   1, 8'd0, 8'd0, 8'd0);
      stim_table[7]  = make_row(8'h01, 8'hFF, 8'd1,   8'd1,   8'd1,   1, 8'd1, 8'd1, 8'd1);
      stim_table[8]  = make_row(8'h01, 8'hFF, 8'd200, 8'd100, 8'd50,  0, 0, 0, 0);
      // negative
      stim_table[9]  = make_row(8'h02, 8'hFF, 8'd0,   8'd0,   8'd0,
                                1, 8'd254, 8'd254, 8'd254);
      stim_table[10] = make_row(8'h02, 8'hFF, 8'd255, 8'd255, 8'd255, 1, 8'd1, 8'd1, 8'd1);
      stim_table[11] = make_row(8'h02, 8'hFF, 8'h55,  8'hAA,  8'h0F,  0, 0, 0, 0);
      // pass-through mode leaves the pixel as it is
      stim_table[12] = make_row(8'h03, 8'hFF, 8'h12,  8'h34,  8'h56,
                                1, 8'h12, 8'h34, 8'h56);
      stim_table[13] = make_row(8'h03, 8'hFF, 8'hFF,  8'h00,  8'h81,
                                1, 8'hFF, 8'h00, 8'h81);
      // clamp at zero and at 100, low bit lifts the result above the clamp
      stim_table[14] = make_row(8'h00, 8'h00, 8'd255, 8'd255, 8'd255, 1, 8'd1, 8'd1, 8'd1);
      stim_table[15] = make_row(8'h00, 8'h00, 8'd254, 8'd254, 8'd254, 1, 8'd0, 8'd0, 8'd0);
      stim_table[16] = make_row(8'h01, 8'd100, 8'd255, 8'd254, 8'd253,
                                1, 8'd101, 8'd100, 8'd101);
      stim_table[17] = make_row(8'h01, 8'd100, 8'd10, 8'd10,  8'd10,  0, 0, 0, 0);
      // upper mode bits masked off; negative ignores the clamp
      stim_table[18] = make_row(8'hFE, 8'h00, 8'd0,   8'd0,   8'd0,
                                1, 8'd254, 8'd254, 8'd254);
      stim_table[19] = make_row(8'hFE, 8'h00, 8'h80,  8'h7F,  8'h01,  0, 0, 0, 0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      cur_mode_data = 8'h00;
      cur_max_data  = rpcf_pkg::MAX_COLOR_RESET;
      for (int i = 0; i < ROWS; i++) begin
         if (stim_table[i].mode_data != cur_mode_data ||
             stim_table[i].max_data != cur_max_data) begin
            drain_pixels();
            write_csr(rpcf_pkg::CSR_FILTER_MODE, stim_table[i].mode_data);
            write_csr(rpcf_pkg::CSR_MAX_COLOR, stim_table[i].max_data);
            cur_mode_data = stim_table[i].mode_data;
            cur_max_data  = stim_table[i].max_data;
         end
         offer_pixel(stim_table[i].px, stim_table[i].typed, stim_table[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_pixels();
         mode_pick = 2'(ph % 4);
         case (ph)
            0, 1, 2, 3: max_pick = 8'd255;
            4:          max_pick = 8'd0;
            5:          max_pick = 8'd1;
            default:    max_pick = 8'($urandom);
         endcase
         write_csr(rpcf_pkg::CSR_FILTER_MODE, {6'($urandom_range(63)), mode_pick});
         write_csr(rpcf_pkg::CSR_MAX_COLOR, max_pick);
         if (ph == 2 || ph == 7) begin
            // writes to unused indexes must leave both registers alone
            write_csr(CSR_SPARE_LO, 8'($urandom));
            write_csr(CSR_SPARE_HI, 8'($urandom));
         end
         if (ph == 3 || ph == 8) begin
            hold_off_go <= 1'b1;
         end
         steady     = (ph == 1 || ph == 6);
         burst_left = 0;
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            if (!steady && burst_left == 0) begin
               gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap > 0) begin
                  idle_cycles(gap);
               end
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            px.red_in   = pick_level();
            px.green_in = pick_level();
            px.blue_in  = pick_level();
            offer_pixel(px, 1'b0, none);
         end
      end

      drain_pixels();
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("[rgb_pixel_color_filter] OK");
      end else begin
         $display("[rgb_pixel_color_filter] ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/rpcf_pkg.sv
hw/rtl/rpcf_mult_stage.sv
hw/rtl/rpcf_sum_stage.sv
hw/rtl/rpcf_out_stage.sv
hw/rtl/rgb_pixel_color_filter.sv
tb/sv/rgb_pixel_color_filter_test.sv
